### design/ps2mct_pkg.sv
// Package for the PS/2 mouse cursor tracker.
// Types, mode and register codes, reset values and button codes.
// No dependencies.
`default_nettype none

package ps2mct_pkg;

  localparam int unsigned COORD_BITS_DEF = 12;
  localparam int unsigned SIZE_BITS      = 13;
  localparam int unsigned CODE_BITS      = 7;

  localparam logic [SIZE_BITS-1:0] SCREEN_W_RST = 13'd640;
  localparam logic [SIZE_BITS-1:0] SCREEN_H_RST = 13'd480;

  localparam logic [CODE_BITS-1:0] CODE_NONE  = 7'd127;
  localparam logic [CODE_BITS-1:0] CODE_LEFT  = 7'd1;
  localparam logic [CODE_BITS-1:0] CODE_RIGHT = 7'd2;
  localparam logic [CODE_BITS-1:0] CODE_MID   = 7'd3;

  typedef enum logic [1:0] {
    MODE_BYTE       = 2'd0,
    MODE_RD_PRESS   = 2'd1,
    MODE_RD_RELEASE = 2'd2
  } mode_e;

  typedef enum logic [0:0] {
    REG_SCREEN_W = 1'b0,
    REG_SCREEN_H = 1'b1
  } reg_idx_e;

  typedef struct packed {
    mode_e      mode;
    logic       aux;
    logic [7:0] data;
  } item_t;

endpackage

`default_nettype wire

### design/ps2_mouse_cursor_tracker.sv
// An accepted item is held in the input register, which feeds the result register that drives the output.
// Throughput: one item per cycle; each item gives exactly one result.
// Only the result register stalling on m_axis_tready holds back input.
// Reset (rst_ni low, async): cursor at (320, 240), latches 127, screen 640 x 480,
// byte count and buttons cleared, both stages empty.
// Depends on ps2mct_pkg, ps2mct_in_stage, ps2mct_core, ps2mct_out_stage.
`default_nettype none

module ps2_mouse_cursor_tracker import ps2mct_pkg::*; #(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF,
  localparam int unsigned OUT_BITS  = 2 * COORD_BITS + 2 * CODE_BITS,
  localparam int unsigned OUT_W     = ((OUT_BITS + 7) / 8) * 8
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [0:0]           cfg_idx_i,
  input  wire logic [SIZE_BITS-1:0] cfg_wdata_i,
  input  wire logic                 s_axis_tvalid,
  output logic                      s_axis_tready,
  input  wire logic [7:0]           s_axis_tdata,  // data_byte
  input  wire logic [2:0]           s_axis_tuser,  // mode[1:0], aux_flag
  output logic                      m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  output logic [OUT_W-1:0]          m_axis_tdata,  // cursor_x, cursor_y, press_code, release_code
  output logic [0:0]                m_axis_tuser   // packet_done
);

  item_t                 s_item, c_item;
  logic                  c_valid, out_free, adv;
  logic [COORD_BITS-1:0] cur_x, cur_y;
  logic [CODE_BITS-1:0]  press, rel;
  logic                  done;
  logic [OUT_W-1:0]      res;

  assign s_item.mode = mode_e'(s_axis_tuser[1:0]);
  assign s_item.aux  = s_axis_tuser[2];
  assign s_item.data = s_axis_tdata;

  ps2mct_in_stage u_in (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid),
    .ready_o (s_axis_tready),
    .item_i  (s_item),
    .adv_i   (adv),
    .valid_o (c_valid),
    .item_o  (c_item)
  );

  assign adv = c_valid && out_free;

  ps2mct_core #(.COORD_BITS(COORD_BITS)) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (reg_idx_e'(cfg_idx_i)),
    .cfg_wdata_i (cfg_wdata_i),
    .fire_i      (adv),
    .item_i      (c_item),
    .cursor_x_o  (cur_x),
    .cursor_y_o  (cur_y),
    .press_o     (press),
    .release_o   (rel),
    .done_o      (done)
  );

  assign res = OUT_W'({rel, press, cur_y, cur_x});

  ps2mct_out_stage #(.DATA_W(OUT_W)) u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (adv),
    .data_i  (res),
    .user_i  (done),
    .free_o  (out_free),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .data_o  (m_axis_tdata),
    .user_o  (m_axis_tuser[0])
  );

endmodule

`default_nettype wire

### design/ps2mct_in_stage.sv
// Input register of the cursor tracker: holds one accepted item.
// Depends on ps2mct_pkg.
`default_nettype none

module ps2mct_in_stage import ps2mct_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  valid_i,
  output logic       ready_o,
  input  wire item_t item_i,
  input  wire logic  adv_i,
  output logic       valid_o,
  output item_t      item_o
);

  logic  valid_q, valid_d;
  item_t item_q;

  assign ready_o = !valid_q || adv_i;
  assign valid_d = valid_i ? 1'b1 : (valid_q && !adv_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

`default_nettype wire

### design/ps2mct_core.sv
// Packet assembly, cursor update with clamp, button event latches.
// State and config registers; result logic is combinational. Depends on ps2mct_pkg.
`default_nettype none

module ps2mct_core import ps2mct_pkg::*; #(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire reg_idx_e              cfg_idx_i,
  input  wire logic [SIZE_BITS-1:0]  cfg_wdata_i,
  input  wire logic                  fire_i,
  input  wire item_t                 item_i,
  output logic [COORD_BITS-1:0]      cursor_x_o,
  output logic [COORD_BITS-1:0]      cursor_y_o,
  output logic [CODE_BITS-1:0]       press_o,
  output logic [CODE_BITS-1:0]       release_o,
  output logic                       done_o
);

  localparam int unsigned VW = COORD_BITS + 2;
  localparam int unsigned TW = (COORD_BITS > SIZE_BITS) ? COORD_BITS : SIZE_BITS;
  localparam logic [COORD_BITS-1:0] CMAX  = '1;
  localparam logic [COORD_BITS-1:0] X_RST = COORD_BITS'(SCREEN_W_RST >> 1);
  localparam logic [COORD_BITS-1:0] Y_RST = COORD_BITS'(SCREEN_H_RST >> 1);

  logic [SIZE_BITS-1:0]  width_q, height_q;
  logic [1:0]            idx_q, idx_d;
  logic [7:0]            pkt0_q, pkt1_q;
  logic [2:0]            btn_q, btn_d;
  logic [COORD_BITS-1:0] x_q, x_d, y_q, y_d;
  logic [CODE_BITS-1:0]  press_q, press_d, rel_q, rel_d;
  logic [CODE_BITS-1:0]  press_n, rel_n;
  logic                  is_byte, last;
  logic [2:0]            rise, fall;
  logic signed [VW-1:0]  sum_x, sum_y;

  function automatic logic [COORD_BITS-1:0] top_of(input logic [SIZE_BITS-1:0] size);
    logic [SIZE_BITS-1:0] m1;
    m1 = size - SIZE_BITS'(1);
    if (size == '0) begin
      return '0;
    end else if (TW'(m1) > TW'(CMAX)) begin
      return CMAX;
    end else begin
      return COORD_BITS'(m1);
    end
  endfunction

  function automatic logic [COORD_BITS-1:0] clamp(input logic signed [VW-1:0] v,
                                                   input logic [COORD_BITS-1:0] top);
    if (v[VW-1]) begin
      return '0;
    end else if (v > $signed({2'b00, top})) begin
      return top;
    end else begin
      return v[COORD_BITS-1:0];
    end
  endfunction

  assign is_byte = (item_i.mode == MODE_BYTE) && item_i.aux;
  assign last    = is_byte && idx_q[1];

  assign sum_x = $signed({2'b00, x_q}) + $signed({{(VW-8){pkt1_q[7]}}, pkt1_q});
  assign sum_y = $signed({2'b00, y_q}) - $signed({{(VW-8){item_i.data[7]}}, item_i.data});

  assign rise = pkt0_q[2:0] & ~btn_q;
  assign fall = ~pkt0_q[2:0] & btn_q;

  always_comb begin
    x_d     = x_q;
    y_d     = y_q;
    btn_d   = btn_q;
    press_n = press_q;
    rel_n   = rel_q;
    idx_d   = idx_q;
    if (is_byte) begin
      idx_d = last ? 2'd0 : idx_q + 2'd1;
    end
    if (last) begin
      x_d   = clamp(sum_x, top_of(width_q));
      y_d   = clamp(sum_y, top_of(height_q));
      btn_d = pkt0_q[2:0];
      if (rise[2]) begin
        press_n = CODE_MID;
      end else if (rise[1]) begin
        press_n = CODE_RIGHT;
      end else if (rise[0]) begin
        press_n = CODE_LEFT;
      end
      if (fall[2]) begin
        rel_n = CODE_MID;
      end else if (fall[1]) begin
        rel_n = CODE_RIGHT;
      end else if (fall[0]) begin
        rel_n = CODE_LEFT;
      end
    end
    press_d = press_n;
    rel_d   = rel_n;
    case (item_i.mode)
      MODE_RD_PRESS:   press_d = CODE_NONE;
      MODE_RD_RELEASE: rel_d   = CODE_NONE;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= 2'd0;
      btn_q   <= 3'd0;
      x_q     <= X_RST;
      y_q     <= Y_RST;
      press_q <= CODE_NONE;
      rel_q   <= CODE_NONE;
    end else if (fire_i) begin
      idx_q   <= idx_d;
      btn_q   <= btn_d;
      x_q     <= x_d;
      y_q     <= y_d;
      press_q <= press_d;
      rel_q   <= rel_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= SCREEN_W_RST;
      height_q <= SCREEN_H_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_SCREEN_W: width_q  <= cfg_wdata_i;
        REG_SCREEN_H: height_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // packet bytes: no reset, always written before read
  always_ff @(posedge clk_i) begin
    if (fire_i && is_byte && !idx_q[1]) begin
      if (idx_q[0]) begin
        pkt1_q <= item_i.data;
      end else begin
        pkt0_q <= item_i.data;
      end
    end
  end

  assign cursor_x_o = x_d;
  assign cursor_y_o = y_d;
  assign press_o    = press_n;
  assign release_o  = rel_n;
  assign done_o     = last;

endmodule

`default_nettype wire

### design/ps2mct_out_stage.sv
// Result register of the cursor tracker with downstream handshake.
// Depends on ps2mct_pkg.
`default_nettype none

module ps2mct_out_stage import ps2mct_pkg::*; #(
  parameter int unsigned DATA_W = 40
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              load_i,
  input  wire logic [DATA_W-1:0] data_i,
  input  wire logic              user_i,
  output logic                   free_o,
  output logic                   valid_o,
  input  wire logic              ready_i,
  output logic [DATA_W-1:0]      data_o,
  output logic                   user_o
);

  logic              valid_q;
  logic [DATA_W-1:0] data_q;
  logic              user_q;

  assign free_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (free_o) begin
      valid_q <= load_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= data_i;
      user_q <= user_i;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;
  assign user_o  = user_q;

endmodule

`default_nettype wire

### design/ps2mct_checker.sv
// Port-level checker for ps2_mouse_cursor_tracker, attached by bind.
// Depends on ps2mct_pkg.
`default_nettype none

module ps2mct_checker import ps2mct_pkg::*; #(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF,
  localparam int unsigned OUT_BITS  = 2 * COORD_BITS + 2 * CODE_BITS,
  localparam int unsigned OUT_W     = ((OUT_BITS + 7) / 8) * 8
) (
  input wire logic                 clk_i,
  input wire logic                 rst_ni,
  input wire logic                 s_axis_tvalid,
  input wire logic                 s_axis_tready,
  input wire logic                 m_axis_tvalid,
  input wire logic                 m_axis_tready,
  input wire logic [OUT_W-1:0]     m_axis_tdata,
  input wire logic [0:0]           m_axis_tuser
);

  localparam int unsigned PL = 2 * COORD_BITS;
  localparam int unsigned RL = PL + CODE_BITS;

  logic [CODE_BITS-1:0] press_c, rel_c;

  assign press_c = m_axis_tdata[PL +: CODE_BITS];
  assign rel_c   = m_axis_tdata[RL +: CODE_BITS];

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // latch codes are a button or no event
  a_codes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |->
      (press_c == CODE_NONE || press_c == CODE_LEFT ||
       press_c == CODE_RIGHT || press_c == CODE_MID) &&
      (rel_c == CODE_NONE || rel_c == CODE_LEFT ||
       rel_c == CODE_RIGHT || rel_c == CODE_MID))
    else $error("bad button code");

  // one item of buffering behind a stalled result
  a_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready && s_axis_tvalid && s_axis_tready |=>
      !s_axis_tready || m_axis_tready)
    else $error("input taken beyond buffer space");

  // result register empty out of reset
  a_reset_empty: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !m_axis_tvalid)
    else $error("result valid out of reset");

endmodule

bind ps2_mouse_cursor_tracker ps2mct_checker #(.COORD_BITS(COORD_BITS)) u_ps2mct_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
